### rtl/fpsa_pkg.sv
package fpsa_pkg;

  // Field and register widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_IDX_W = 1;

  // Default line-store geometry
  localparam int unsigned MAX_WIDTH_DEF  = 512;
  localparam int unsigned MAX_HEIGHT_DEF = 512;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Configuration reset values
  localparam logic [CFG_W-1:0] ROW_WIDTH_RST    = 10'd512;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 10'd512;

  // Five-sample sum and round-to-nearest divide by five.
  // |sum| + 2 stays below 2^18, so ceil(2^20 / 5) gives an exact quotient.
  localparam int unsigned SUM_W      = 19;
  localparam int unsigned MAG_W      = 18;
  localparam int unsigned PROD_W     = 36;
  localparam int unsigned DIV5_SHIFT = 20;
  localparam logic [MAG_W-1:0] DIV5_MUL  = 18'd209716;
  localparam logic [MAG_W-1:0] DIV5_BIAS = 18'd2;

  localparam logic signed [SAMPLE_W:0] RES_MAX = 17'sd32767;
  localparam logic signed [SAMPLE_W:0] RES_MIN = -17'sd32768;

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample_in;
  } fpsa_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smoothed;
    logic                       frame_last;
  } fpsa_out_t;

endpackage

### rtl/five_point_stencil_average_core.sv
// Streaming five-point smoothing over a raster frame with zero padding at the borders.
// Samples (signed Q1.15) enter in raster order, one transaction per clock unless stalled;
// every result is the mean of a position and its up, left, right and down neighbors,
// rounded to nearest and saturated to Q1.15, and comes out one row behind the input, so
// the last frame row is drained with a row of flush transactions (cmd = 1, worth zero).
// The final result of a frame carries frame_last. The line store is two banks of
// MAX_WIDTH x 16 bit synchronous RAM, one per row parity; every transaction takes one
// read from each bank (the row above from one, the middle row one column ahead from the
// other), which sets the rate at one transaction per clock while not stalled. After reset
// the block clears both banks in parallel and holds in_stall_o high until every entry
// is cleared; configuration writes are taken during that time. Change row_width or
// frame_height only while no transaction is in flight.
module five_point_stencil_average_core #(
  parameter int unsigned MAX_WIDTH  = fpsa_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = fpsa_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fpsa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fpsa_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  fpsa_pkg::fpsa_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output fpsa_pkg::fpsa_out_t                 out_data_o
);

  import fpsa_pkg::*;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WW_RAW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW_RAW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WW     = (WW_RAW > CFG_W) ? WW_RAW : CFG_W;
  localparam int unsigned HW     = (HW_RAW > CFG_W) ? HW_RAW : CFG_W;

  // Control and data of one transaction between the accept and the RAM read data.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] val;
    logic [COL_W-1:0]           col;
    logic                       bank;
    logic                       c0;
    logic                       rt_zero;
    logic                       up_zero;
    logic                       dn_zero;
    logic                       has_out;
    logic                       frame_end;
  } s1_t;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] row_width_q;
  logic [CFG_W-1:0] frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q    <= ROW_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROW_WIDTH:    row_width_q    <= cfg_wdata_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default:          row_width_q    <= row_width_q;
      endcase
    end
  end

  // Saturate the registers to the geometry the line store supports.
  logic [WW-1:0] rw_ext;
  logic [WW-1:0] w_use;
  logic [HW-1:0] fh_ext;
  logic [HW-1:0] h_use;

  always_comb begin
    rw_ext = WW'(row_width_q);
    fh_ext = HW'(frame_height_q);
    if (rw_ext < WW'(3)) begin
      w_use = WW'(3);
    end else if (rw_ext > WW'(MAX_WIDTH)) begin
      w_use = WW'(MAX_WIDTH);
    end else begin
      w_use = rw_ext;
    end
    if (fh_ext < HW'(1)) begin
      h_use = HW'(1);
    end else if (fh_ext > HW'(MAX_HEIGHT)) begin
      h_use = HW'(MAX_HEIGHT);
    end else begin
      h_use = fh_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake chain: accept -> s1 (RAM data) -> s2 (sum) -> s3 (magnitude)
  //                  -> s4 (product) -> output register
  // ---------------------------------------------------------------------------
  logic in_fire;
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  logic s1_adv, s2_adv, s3_adv, s4_adv;
  logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;
  s1_t  s1_q, s1_d;
  logic clr_busy_q;
  logic [COL_W-1:0] clr_addr_q;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s4_adv    = s4_valid_q && out_ready;
  assign s4_ready  = !s4_valid_q || out_ready;
  assign s3_adv    = s3_valid_q && s4_ready;
  assign s3_ready  = !s3_valid_q || s4_ready;
  assign s2_adv    = s2_valid_q && s3_ready;
  assign s2_ready  = !s2_valid_q || s3_ready;
  // A transaction of the first row produces no result and just leaves s1.
  assign s1_adv    = s1_valid_q && (!s1_q.has_out || s2_ready);
  assign s1_ready  = !s1_valid_q || s1_adv;

  assign in_stall_o = clr_busy_q || !s1_ready;
  assign in_fire    = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Input position and stage 0 decode
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic             row_end;
  logic             last_row;
  logic             has_out;
  logic             frame_end_d;
  logic [COL_W-1:0] ctr_raddr;

  always_comb begin
    row_end     = WW'(in_col_q) >= (w_use - WW'(1));
    last_row    = HW'(in_row_q) >= h_use;
    has_out     = in_row_q != '0;
    frame_end_d = has_out && last_row && row_end;

    s1_d.val       = (!in_data_i.cmd && !last_row) ? in_data_i.sample_in : '0;
    s1_d.col       = in_col_q;
    s1_d.bank      = in_row_q[0];
    s1_d.c0        = in_col_q == '0;
    s1_d.rt_zero   = row_end;
    s1_d.up_zero   = in_row_q == ROW_W'(1);
    s1_d.dn_zero   = last_row;
    s1_d.has_out   = has_out;
    s1_d.frame_end = frame_end_d;

    // Fetch the middle row one column ahead; nothing to fetch at the row end.
    ctr_raddr = row_end ? in_col_q : in_col_q + COL_W'(1);

    if (frame_end_d) begin
      in_col_d = '0;
      in_row_d = '0;
    end else if (row_end) begin
      in_col_d = '0;
      in_row_d = in_row_q + ROW_W'(1);
    end else begin
      in_col_d = in_col_q + COL_W'(1);
      in_row_d = in_row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
    end else if (in_fire) begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing pass: zero both banks after reset
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + COL_W'(1);
      if (clr_addr_q == COL_W'(MAX_WIDTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: bank b holds the rows of parity b. The bank of the input row
  // gives the row above and takes the new sample; the other bank gives the
  // middle row. The write goes out when the transaction leaves s1, so it never
  // meets a read of the same entry.
  // ---------------------------------------------------------------------------
  logic [1:0]          ram_we;
  logic [COL_W-1:0]    ram_waddr [2];
  logic [COL_W-1:0]    ram_raddr [2];
  logic [SAMPLE_W-1:0] ram_rdata [2];
  logic [SAMPLE_W-1:0] ram_wdata;

  assign ram_wdata = clr_busy_q ? '0 : s1_q.val;

  for (genvar b = 0; b < 2; b++) begin : g_bank
    always_comb begin
      ram_raddr[b] = (in_row_q[0] == 1'(b)) ? in_col_q : ctr_raddr;
      ram_we[b]    = clr_busy_q || (s1_adv && (s1_q.bank == 1'(b)));
      ram_waddr[b] = clr_busy_q ? clr_addr_q : s1_q.col;
    end

    fpsa_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WIDTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (ram_we[b]),
      .waddr_i (ram_waddr[b]),
      .wdata_i (ram_wdata),
      .re_i    (in_fire),
      .raddr_i (ram_raddr[b]),
      .rdata_o (ram_rdata[b])
    );
  end

  // ---------------------------------------------------------------------------
  // s1: assemble the window and add
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] up_raw, rt_raw;
  logic signed [SAMPLE_W-1:0] up_v, lf_v, ce_v, rt_v, dn_v;
  logic signed [SAMPLE_W-1:0] tap_nxt_q;  // raw middle-row sample one column right
  logic signed [SAMPLE_W-1:0] tap_cur_q;  // middle-row sample at the last position
  logic signed [SAMPLE_W-1:0] col0_q;     // first sample of the latest input row
  logic signed [SUM_W-1:0]    sum_d, sum_q;

  always_comb begin
    up_raw = ram_rdata[s1_q.bank];
    rt_raw = ram_rdata[~s1_q.bank];
    up_v   = s1_q.up_zero ? '0 : up_raw;
    ce_v   = s1_q.c0 ? col0_q : tap_nxt_q;
    lf_v   = s1_q.c0 ? '0 : tap_cur_q;
    rt_v   = s1_q.rt_zero ? '0 : rt_raw;
    dn_v   = s1_q.dn_zero ? '0 : s1_q.val;
    sum_d  = SUM_W'(up_v) + SUM_W'(lf_v) + SUM_W'(ce_v) + SUM_W'(rt_v) + SUM_W'(dn_v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire || (s1_valid_q && !s1_adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    // Slide the middle-row window; remember the row start for the next row.
    if (s1_adv) begin
      tap_nxt_q <= rt_raw;
      tap_cur_q <= ce_v;
      if (s1_q.c0) begin
        col0_q <= s1_q.val;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // s2 -> s3 -> s4 -> output: round half away from zero, divide by five
  // ---------------------------------------------------------------------------
  logic                 s2_last_q, s3_last_q, s4_last_q;
  logic                 s3_neg_q, s4_neg_q;
  logic signed [SUM_W-1:0] abs_sum;
  logic [MAG_W-1:0]     mag_d, mag_q;
  logic [PROD_W-1:0]    prod_d, prod_q;
  logic [SAMPLE_W-1:0]  quot;
  logic signed [SAMPLE_W:0] res_wide;
  fpsa_out_t            out_d, out_q;

  always_comb begin
    abs_sum = sum_q[SUM_W-1] ? -sum_q : sum_q;
    mag_d   = MAG_W'(abs_sum) + DIV5_BIAS;
    prod_d  = mag_q * DIV5_MUL;
    quot    = prod_q[DIV5_SHIFT +: SAMPLE_W];
    res_wide = s4_neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    if (res_wide > RES_MAX) begin
      out_d.smoothed = SAMPLE_W'(RES_MAX);
    end else if (res_wide < RES_MIN) begin
      out_d.smoothed = SAMPLE_W'(RES_MIN);
    end else begin
      out_d.smoothed = SAMPLE_W'(res_wide);
    end
    out_d.frame_last = s4_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= (s1_adv && s1_q.has_out) || (s2_valid_q && !s2_adv);
      s3_valid_q  <= s2_adv || (s3_valid_q && !s3_adv);
      s4_valid_q  <= s3_adv || (s4_valid_q && !s4_adv);
      out_valid_q <= s4_adv || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.has_out) begin
      sum_q     <= sum_d;
      s2_last_q <= s1_q.frame_end;
    end
    if (s2_adv) begin
      mag_q     <= mag_d;
      s3_neg_q  <= sum_q[SUM_W-1];
      s3_last_q <= s2_last_q;
    end
    if (s3_adv) begin
      prod_q    <= prod_d;
      s4_neg_q  <= s3_neg_q;
      s4_last_q <= s3_last_q;
    end
    if (s4_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Hold the RAM read data while s1 waits: no new read may be issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> !in_fire)
    else $error("line store read issued while s1 holds its data");

  // The deferred write must never hit the entry being read in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we[0] && in_fire) |-> (ram_waddr[0] != ram_raddr[0]))
    else $error("bank 0 read and write collide");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we[1] && in_fire) |-> (ram_waddr[1] != ram_raddr[1]))
    else $error("bank 1 read and write collide");

  // The transaction that ends a frame returns the input position to the origin.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && frame_end_d) |=> (in_row_q == '0 && in_col_q == '0))
    else $error("input position not restarted after frame end");

endmodule

### rtl/fpsa_ram.sv
module fpsa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### verif/tb_five_point_stencil_average_core.sv
`timescale 1ns / 100ps

module tb_five_point_stencil_average_core;
  import fpsa_pkg::*;

  localparam int unsigned LINE_MAX       = MAX_WIDTH_DEF;
  localparam int unsigned ROWS_MAX       = MAX_HEIGHT_DEF;
  // Results still pass through the pipeline after the completing transaction; leave margin.
  localparam int unsigned SETTLE_CYCLES  = 16;
  // Covers the line-store clearing pass after reset plus worst stall bursts.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned ITEM_TARGET    = 1080;
  // No idling once this many transactions have been queued.
  localparam int unsigned CALM_TAIL      = 980;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ROW_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  fpsa_in_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  fpsa_out_t            out_data;

  // Stimulus and scoreboard storage
  fpsa_in_t  sample_q [$];   // transactions waiting for the driver
  fpsa_out_t mean_q [$];     // predicted smoothed results, oldest first

  // Predictor copy of the block: register mirror, two row banks, raster position
  logic [CFG_W-1:0] width_reg  = ROW_WIDTH_RST;
  logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RST;
  int               row_bank [2*LINE_MAX];
  int unsigned      next_col;
  int unsigned      next_row;
  int unsigned      out_row;

  // Run control and bookkeeping
  bit          idle_on = 1'b1;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned fault_count;
  int unsigned n_sent;
  int unsigned n_results;
  int unsigned n_frames;
  int unsigned n_writes;

  five_point_stencil_average_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Divide a five-sample sum by five, round half away from zero, saturate to Q1.15.
  function automatic logic signed [SAMPLE_W-1:0] fifth_rounded(int total);
    int q;
    q = (total >= 0) ? (total + 2) / 5 : -((2 - total) / 5);
    if (q > RES_MAX) q = int'(RES_MAX);
    else if (q < RES_MIN) q = int'(RES_MIN);
    return q[SAMPLE_W-1:0];
  endfunction

  // Advance the predictor by one accepted transaction and queue the result it completes.
  function automatic void predict_mean(fpsa_in_t item);
    int unsigned w, h, col, upb, cnb;
    bit          row_end, last_row, frame_end;
    int          val, up, lf, ce, rt, dn;
    fpsa_out_t   res;
    // Saturate out-of-range registers to the usable geometry
    w = (width_reg < 3) ? 3 : (width_reg > LINE_MAX) ? LINE_MAX : width_reg;
    h = (height_reg < 1) ? 1 : (height_reg > ROWS_MAX) ? ROWS_MAX : height_reg;
    col = next_col;
    row_end = (col >= w - 1);
    // Flush items and anything in the drain row count as zero
    val = (!item.cmd && next_row < h) ? int'(item.sample_in) : 0;
    frame_end = 1'b0;
    if (col >= LINE_MAX) col = LINE_MAX - 1;
    if (next_row >= 1) begin
      upb = (next_row % 2) * LINE_MAX;
      cnb = (out_row % 2) * LINE_MAX;
      last_row = (out_row >= h - 1);
      up = (out_row == 0) ? 0 : row_bank[upb + col];
      lf = (col == 0) ? 0 : row_bank[cnb + col - 1];
      ce = row_bank[cnb + col];
      rt = (row_end || col + 1 >= LINE_MAX) ? 0 : row_bank[cnb + col + 1];
      dn = last_row ? 0 : val;
      frame_end = last_row && row_end;
      res.smoothed = fifth_rounded(up + lf + ce + rt + dn);
      res.frame_last = frame_end;
      mean_q.push_back(res);
    end
    // The incoming sample overwrites the row-above entry it has just been averaged with
    row_bank[(next_row % 2) * LINE_MAX + col] = val;
    if (frame_end) begin
      next_col = 0;
      next_row = 0;
    end else if (row_end) begin
      next_col = 0;
      next_row = (next_row + 1) % 1024;
    end else begin
      next_col = col + 1;
    end
    out_row = (next_row >= 1) ? (next_row - 1) % 512 : 0;
  endfunction

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void check_mean(fpsa_out_t got);
    fpsa_out_t want;
    n_results++;
    if (got.frame_last) n_frames++;
    if (mean_q.size() == 0) begin
      note_fault($sformatf("result with nothing pending: smoothed %0d frame_last %0b",
                           got.smoothed, got.frame_last));
    end else begin
      want = mean_q.pop_front();
      if (got.smoothed !== want.smoothed)
        note_fault($sformatf("result %0d smoothed: expected %0d, got %0d",
                             n_results, want.smoothed, got.smoothed));
      if (got.frame_last !== want.frame_last)
        note_fault($sformatf("result %0d frame_last: expected %0b, got %0b",
                             n_results, want.frame_last, got.frame_last));
    end
  endfunction

  // Driver: hold the payload while stalled, otherwise load the next transaction or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (idle_on && sample_q.size() != 0 && $urandom_range(0, 7) == 0) begin
        // Start an idle burst of random length
        in_valid <= 1'b0;
        gap_left <= $urandom_range(0, 8);
      end else if (sample_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= sample_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure: stall bursts of random length while idling is enabled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      hold_left <= $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: check results, predict from accepted inputs, and run the watchdog.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) check_mean(out_data);
      if (in_valid && !in_stall) predict_mean(in_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT - 1) begin
        $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, mean_q.size());
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_ROW_WIDTH) width_reg = val;
    else height_reg = val;
    n_writes++;
    @(negedge clk_i);
  endtask

  // Wait until everything queued was taken and answered, then let trailing work settle.
  task automatic wait_idle();
    @(negedge clk_i);
    while (sample_q.size() != 0 || in_valid || mean_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic retune(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    wait_idle();
    write_reg(idx, val);
  endtask

  task automatic push_item(bit cmd, int v);
    fpsa_in_t it;
    it.cmd       = cmd;
    it.sample_in = v[SAMPLE_W-1:0];
    sample_q.push_back(it);
    n_sent++;
  endtask

  // Mostly uniform samples, with the Q1.15 extremes and values around zero mixed in.
  function automatic int pick_sample();
    case ($urandom_range(0, 11))
      0:       return 32767;
      1:       return -32768;
      2:       return 0;
      3:       return -1;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Queue whole frames: h rows of samples (some flushed) plus one drain row.
  task automatic queue_frames(int unsigned w, int unsigned h, int unsigned count);
    for (int f = 0; f < count; f++)
      for (int r = 0; r <= h; r++)
        for (int c = 0; c < w; c++)
          if (r < h) push_item($urandom_range(0, 9) == 0, pick_sample());
          else push_item($urandom_range(0, 4) != 0, pick_sample());
  endtask

  initial begin
    int unsigned      w, h;
    logic [CFG_W-1:0] w_raw, h_raw;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Saturated positive frame 3x3; the drain row mixes live samples that must read as zero
    write_reg(CFG_ROW_WIDTH, 10'd0);
    write_reg(CFG_FRAME_HEIGHT, 10'd3);
    for (int i = 0; i < 9; i++) push_item(1'b0, 32767);
    push_item(1'b0, -32768);
    push_item(1'b1, 0);
    push_item(1'b0, 32767);

    // Saturated negative frame with a flush item inside it
    retune(CFG_ROW_WIDTH, 10'd2);
    for (int i = 0; i < 9; i++) push_item(i == 6, -32768);
    for (int i = 0; i < 3; i++) push_item(1'b1, 0);

    // Shrink the height mid-frame: the pending output row becomes the last one
    retune(CFG_ROW_WIDTH, 10'd3);
    write_reg(CFG_FRAME_HEIGHT, 10'd512);
    for (int i = 0; i < 6; i++) push_item(1'b0, pick_sample());
    retune(CFG_FRAME_HEIGHT, 10'd1023);
    for (int i = 0; i < 6; i++) push_item(1'b0, pick_sample());
    retune(CFG_FRAME_HEIGHT, 10'd2);
    for (int i = 0; i < 3; i++) push_item(1'b0, pick_sample());

    // Widest rows, then shrink the width mid-row so the current column ends the frame
    retune(CFG_ROW_WIDTH, 10'd1023);
    write_reg(CFG_FRAME_HEIGHT, 10'd1);
    for (int i = 0; i < 300; i++) push_item($urandom_range(0, 9) == 0, pick_sample());
    retune(CFG_ROW_WIDTH, 10'd512);
    for (int i = 0; i < 222; i++) push_item($urandom_range(0, 9) == 0, pick_sample());
    retune(CFG_ROW_WIDTH, 10'd5);
    push_item(1'b0, pick_sample());

    // Random geometries with well-formed frames; the tail runs at full rate
    while (n_sent < ITEM_TARGET) begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(11, 40) : $urandom_range(3, 10);
      h = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
      w_raw = CFG_W'((w == 3 && $urandom_range(0, 1) == 1) ? $urandom_range(0, 2) : w);
      h_raw = CFG_W'((h == 1 && $urandom_range(0, 1) == 1) ? 0 : h);
      wait_idle();
      idle_on = (n_sent < CALM_TAIL) && ($urandom_range(0, 3) != 0);
      write_reg(CFG_ROW_WIDTH, w_raw);
      write_reg(CFG_FRAME_HEIGHT, h_raw);
      queue_frames(w, h, (n_sent < CALM_TAIL) ? $urandom_range(1, 3) : 1);
    end

    wait_idle();
    $display("Run covered %0d input transactions under %0d register writes,", n_sent, n_writes);
    $display("checking %0d smoothed results across %0d completed frames.", n_results, n_frames);
    if (fault_count == 0 && mean_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results never seen", fault_count, mean_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
